[rtl/core/gpcd_pkg.sv]
package gpcd_pkg;

  localparam int BufferDepth = 16;
  localparam int VramCols = 1024;
  localparam int VramRows = 512;

  typedef enum logic [3:0] {
    K_FILL      = 4'd0,
    K_FLAT_QUAD = 4'd1,
    K_TEX_QUAD  = 4'd2,
    K_SHD_TRI   = 4'd3,
    K_SHD_QUAD  = 4'd4,
    K_SPRITE    = 4'd5,
    K_DOT       = 4'd6,
    K_WR_START  = 4'd7,
    K_RD_START  = 4'd8,
    K_HALFWORD  = 4'd9,
    K_UNHANDLED = 4'd10
  } kind_t;

  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_CCLR   = 8'h01;
  localparam logic [7:0] OP_FILL   = 8'h02;
  localparam logic [7:0] OP_FQUAD  = 8'h28;
  localparam logic [7:0] OP_TQUAD0 = 8'h2c;
  localparam logic [7:0] OP_TQUAD1 = 8'h2d;
  localparam logic [7:0] OP_STRI   = 8'h30;
  localparam logic [7:0] OP_SQUAD  = 8'h38;
  localparam logic [7:0] OP_SPRITE = 8'h65;
  localparam logic [7:0] OP_DOT    = 8'h68;
  localparam logic [7:0] OP_WRITE  = 8'ha0;
  localparam logic [7:0] OP_READ   = 8'hc0;
  localparam logic [7:0] OP_E1     = 8'he1;
  localparam logic [7:0] OP_E2     = 8'he2;
  localparam logic [7:0] OP_E3     = 8'he3;
  localparam logic [7:0] OP_E4     = 8'he4;
  localparam logic [7:0] OP_E5     = 8'he5;
  localparam logic [7:0] OP_E6     = 8'he6;

  typedef struct packed {
    kind_t              kind;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         tex_u;
    logic [7:0]         tex_v;
    logic [9:0]         clut_col;
    logic [8:0]         clut_row;
    logic [8:0]         page_bits;
    logic               last;
  } result_t;

  function automatic logic [4:0] packet_len(input logic [7:0] op);
    case (op)
      OP_FILL:              packet_len = 5'd3;
      OP_FQUAD:             packet_len = 5'd5;
      OP_TQUAD0, OP_TQUAD1: packet_len = 5'd9;
      OP_STRI:              packet_len = 5'd6;
      OP_SQUAD:             packet_len = 5'd8;
      OP_SPRITE:            packet_len = 5'd4;
      OP_DOT:               packet_len = 5'd2;
      OP_WRITE, OP_READ:    packet_len = 5'd3;
      default:              packet_len = 5'd1;
    endcase
  endfunction

endpackage

[rtl/core/gpcd_out_queue.sv]
module gpcd_out_queue
  import gpcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res [4],
  input  logic [2:0] load_n,
  output logic    busy,
  output logic    valid,
  input  logic    stall,
  output result_t res
);
  // Holds the results of one input item and hands them out one per cycle while stall is low.
  result_t    slot [4];
  logic [1:0] rd;
  logic [2:0] left;

  assign valid = (left != 3'd0);
  assign res   = slot[rd];
  assign busy  = valid && !(left == 3'd1 && !stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd   <= 2'd0;
      left <= 3'd0;
    end else if (load) begin
      rd   <= 2'd0;
      left <= load_n;
    end else if (valid && !stall) begin
      rd   <= rd + 2'd1;
      left <= left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= load_res;
    end
  end
endmodule

[rtl/core/gpu_command_packet_decoder_core.sv]
// A packet's last word passes the input register, then its results load the output queue.
// Throughput: one word per cycle while no results are pending; a word that yields n results
// holds the input while the result queue drains them, one per cycle while out_stall is low.
// Reset (rst, synchronous) clears word count, mode registers and transfer state;
// the word buffer is not cleared and only entries of the current packet are read.
module gpu_command_packet_decoder_core
  import gpcd_pkg::*;
#(
  parameter int BUFFER_DEPTH = BufferDepth
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         kind,
  output logic signed [11:0] pos_x,
  output logic signed [11:0] pos_y,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         tex_u,
  output logic [7:0]         tex_v,
  output logic [9:0]         clut_col,
  output logic [8:0]         clut_row,
  output logic [8:0]         page_bits,
  output logic               last
);
  localparam int CW = $clog2(BUFFER_DEPTH);

  logic [31:0] buf_q [BUFFER_DEPTH];
  logic [CW-1:0] word_count;
  logic [15:0] draw_mode;
  logic [1:0]  rect_flips;
  logic [19:0] tex_window;
  logic [39:0] draw_area;
  logic [21:0] draw_offset;
  logic        write_active;
  logic [9:0]  wr_x, wr_w, rd_x, rd_w;
  logic [8:0]  wr_y, wr_h, rd_y, rd_h;
  logic [10:0] wr_w_full;
  logic [9:0]  wr_h_full;
  logic [19:0] remain;
  logic [9:0]  col;
  logic [8:0]  row;

  // Input register.
  logic        s1_valid;
  logic [31:0] s1_word;

  logic    q_busy, q_valid, q_load;
  result_t q_res;
  result_t res [4];
  logic [2:0] n_res;

  assign in_stall = s1_valid && q_busy;
  wire take = in_valid && !in_stall;
  wire proc = s1_valid && !q_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (take) begin
      s1_word <= word;
    end
  end

  // Packet view: the word just arriving stands in for its buffer slot.
  logic [31:0] b [BUFFER_DEPTH];
  always_comb begin
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      b[i] = (word_count == CW'(i)) ? s1_word : buf_q[i];
    end
  end

  logic [7:0] op;
  logic       done;
  assign op   = b[0][31:24];
  assign done = ({1'b0, word_count} + 5'd1) == packet_len(op);

  function automatic result_t mk(input kind_t k, input logic [31:0] pt,
                                 input logic [23:0] color, input logic [15:0] crd,
                                 input logic [9:0] cc, input logic [8:0] cr,
                                 input logic [8:0] pg);
    result_t r;
    r.kind      = k;
    r.pos_x     = {pt[10], pt[10:0]};
    r.pos_y     = {pt[26], pt[26:16]};
    r.red       = color[7:0];
    r.green     = color[15:8];
    r.blue      = color[23:16];
    r.tex_u     = crd[7:0];
    r.tex_v     = crd[15:8];
    r.clut_col  = cc;
    r.clut_row  = cr;
    r.page_bits = pg;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic result_t mkr(input kind_t k, input logic [11:0] x,
                                  input logic [11:0] y);
    result_t r;
    r = '0;
    r.kind  = k;
    r.pos_x = x;
    r.pos_y = y;
    return r;
  endfunction

  // Transfer-start rectangle.
  logic [9:0]  nx, nw;
  logic [8:0]  ny, nh;
  logic [10:0] nw_full;
  logic [9:0]  nh_full;
  assign nx      = b[1][9:0];
  assign ny      = b[1][24:16];
  assign nw      = b[2][9:0] - 10'd1;
  assign nh      = b[2][24:16] - 9'd1;
  assign nw_full = {1'b0, nw} + 11'd1;
  assign nh_full = {1'b0, nh} + 10'd1;

  // Transfer: up to two halfwords per word, column/row counters stand for progress.
  logic        hw0, hw1;
  logic [9:0]  col1;
  logic [8:0]  row1, row2;
  logic [9:0]  col2;
  assign hw0 = (remain != 20'd0);
  assign hw1 = (remain > 20'd1);
  always_comb begin
    if ({1'b0, col} + 11'd1 == wr_w_full) begin
      col1 = 10'd0;
      row1 = row + 9'd1;
    end else begin
      col1 = col + 10'd1;
      row1 = row;
    end
    if ({1'b0, col1} + 11'd1 == wr_w_full) begin
      col2 = 10'd0;
      row2 = row1 + 9'd1;
    end else begin
      col2 = col1 + 10'd1;
      row2 = row1;
    end
  end

  logic [10:0] fx1;
  logic [11:0] fx2;
  logic [9:0]  cc;
  logic [8:0]  cr;
  assign fx1 = {b[1][10:4], 4'd0};
  assign fx2 = {b[2][10], b[2][10:0]} + 12'h00f;
  assign cc  = {b[2][21:16], 4'd0};
  assign cr  = b[2][30:22];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = '0;
    end
    n_res = 3'd0;
    if (write_active) begin
      res[0] = mkr(K_HALFWORD, {2'd0, wr_x + col}, {3'd0, wr_y + row});
      res[0].tex_u = s1_word[7:0];
      res[0].tex_v = s1_word[15:8];
      res[1] = mkr(K_HALFWORD, {2'd0, wr_x + col1}, {3'd0, wr_y + row1});
      res[1].tex_u = s1_word[23:16];
      res[1].tex_v = s1_word[31:24];
      n_res = hw1 ? 3'd2 : (hw0 ? 3'd1 : 3'd0);
    end else if (done) begin
      case (op)
        OP_NOP, OP_CCLR, OP_E1, OP_E2, OP_E3, OP_E4, OP_E5, OP_E6: n_res = 3'd0;
        OP_FILL: begin
          res[0] = mk(K_FILL, b[1], b[0][23:0], 16'd0, 10'd0, 9'd0, 9'd0);
          res[0].pos_x = {fx1[10], fx1};
          res[1] = mk(K_FILL, b[2], b[0][23:0], 16'd0, 10'd0, 9'd0, 9'd0);
          res[1].pos_x = {fx2[11:4], 4'd0};
          n_res = 3'd2;
        end
        OP_FQUAD: begin
          for (int i = 0; i < 4; i++) begin
            res[i] = mk(K_FLAT_QUAD, b[1+i], b[0][23:0], 16'd0, 10'd0, 9'd0, 9'd0);
          end
          n_res = 3'd4;
        end
        OP_TQUAD0, OP_TQUAD1: begin
          for (int i = 0; i < 4; i++) begin
            res[i] = mk(K_TEX_QUAD, b[1+2*i], b[0][23:0], b[2+2*i][15:0], cc, cr,
                        b[4][24:16]);
          end
          n_res = 3'd4;
        end
        OP_STRI: begin
          for (int i = 0; i < 3; i++) begin
            res[i] = mk(K_SHD_TRI, b[1+2*i], b[2*i][23:0], 16'd0, 10'd0, 9'd0, 9'd0);
          end
          n_res = 3'd3;
        end
        OP_SQUAD: begin
          for (int i = 0; i < 4; i++) begin
            res[i] = mk(K_SHD_QUAD, b[1+2*i], b[2*i][23:0], 16'd0, 10'd0, 9'd0, 9'd0);
          end
          n_res = 3'd4;
        end
        OP_SPRITE: begin
          res[0] = mk(K_SPRITE, b[1], b[0][23:0], b[2][15:0], cc, cr, draw_mode[8:0]);
          res[1] = mk(K_SPRITE, b[3], 24'd0, 16'd0, 10'd0, 9'd0, 9'd0);
          n_res = 3'd2;
        end
        OP_DOT: begin
          res[0] = mk(K_DOT, b[1], b[0][23:0], 16'd0, 10'd0, 9'd0, 9'd0);
          n_res = 3'd1;
        end
        OP_WRITE, OP_READ: begin
          res[0] = mkr((op == OP_WRITE) ? K_WR_START : K_RD_START,
                       {2'd0, nx}, {3'd0, ny});
          res[1] = mkr((op == OP_WRITE) ? K_WR_START : K_RD_START,
                       {1'b0, nw_full}, {2'd0, nh_full});
          n_res = 3'd2;
        end
        default: begin
          res[0] = mkr(K_UNHANDLED, 12'd0, 12'd0);
          res[0].tex_u = op;
          n_res = 3'd1;
        end
      endcase
    end
    for (int i = 0; i < 4; i++) begin
      if (n_res == 3'(i + 1)) begin
        res[i].last = 1'b1;
      end
    end
  end

  assign q_load = proc && (n_res != 3'd0);

  // The buffer slot is written with the arriving word.
  always_ff @(posedge clk) begin
    if (proc && !write_active) begin
      buf_q[word_count] <= s1_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count   <= '0;
      draw_mode    <= '0;
      rect_flips   <= '0;
      tex_window   <= '0;
      draw_area    <= '0;
      draw_offset  <= '0;
      write_active <= 1'b0;
      wr_x <= '0; wr_y <= '0; wr_w <= '0; wr_h <= '0;
      wr_w_full <= 11'd1; wr_h_full <= 10'd1;
      rd_x <= '0; rd_y <= '0; rd_w <= '0; rd_h <= '0;
      remain <= '0; col <= '0; row <= '0;
    end else if (proc) begin
      if (write_active) begin
        col <= hw1 ? col2 : col1;
        row <= hw1 ? row2 : row1;
        if (hw1) begin
          remain <= remain - 20'd2;
        end else begin
          remain <= '0;
        end
        if (remain <= 20'd2) begin
          write_active <= 1'b0;
        end
      end else if (!done) begin
        word_count <= word_count + CW'(1);
      end else begin
        word_count <= '0;
        case (op)
          OP_WRITE: begin
            wr_x <= nx; wr_y <= ny; wr_w <= nw; wr_h <= nh;
            wr_w_full <= nw_full; wr_h_full <= nh_full;
            remain <= {9'd0, nw_full} * {10'd0, nh_full};
            col <= '0; row <= '0;
            write_active <= 1'b1;
          end
          OP_READ: begin
            rd_x <= nx; rd_y <= ny; rd_w <= nw; rd_h <= nh;
          end
          OP_E1: begin
            draw_mode  <= {s1_word[11], draw_mode[14:11], s1_word[10:0]};
            rect_flips <= s1_word[13:12];
          end
          OP_E2: tex_window <= s1_word[19:0];
          OP_E3: draw_area[19:0] <= s1_word[19:0];
          OP_E4: draw_area[39:20] <= s1_word[19:0];
          OP_E5: draw_offset <= s1_word[21:0];
          OP_E6: draw_mode[12:11] <= s1_word[1:0];
          default: ;
        endcase
      end
    end
  end

  gpcd_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (q_load),
    .load_res (res),
    .load_n   (n_res),
    .busy     (q_busy),
    .valid    (q_valid),
    .stall    (out_stall),
    .res      (q_res)
  );

  assign out_valid = q_valid;
  assign kind      = q_res.kind;
  assign pos_x     = q_res.pos_x;
  assign pos_y     = q_res.pos_y;
  assign red       = q_res.red;
  assign green     = q_res.green;
  assign blue      = q_res.blue;
  assign tex_u     = q_res.tex_u;
  assign tex_v     = q_res.tex_v;
  assign clut_col  = q_res.clut_col;
  assign clut_row  = q_res.clut_row;
  assign page_bits = q_res.page_bits;
  assign last      = q_res.last;

`ifndef SYNTHESIS
  a_cnt_in_write: assert property (@(posedge clk) disable iff (rst)
    write_active |-> word_count == '0) else $error("count moved during transfer");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    q_load |-> !(q_valid && !(out_stall == 1'b0 && q_busy == 1'b0)))
    else $error("queue loaded while busy");
  a_remain: assert property (@(posedge clk) disable iff (rst)
    write_active |-> remain != 20'd0) else $error("empty transfer active");
`endif
endmodule
